FILE: rtl/opr_pkg.sv
// ----------------------------------------------------------------------------
// opr_pkg: shared types and constants for the optimal page replacement block
// Replay sequencer states and the load-to-replay command record.
// ----------------------------------------------------------------------------
package opr_pkg;

    localparam int unsigned PageW = 16;
    localparam int unsigned CntW  = 7;
    localparam int unsigned SlotW = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_HITCHK,
        ST_SCAN,
        ST_EMIT
    } t_rp_state;

    typedef struct packed {
        logic [CntW-1:0] len;
    } t_run_cmd;

endpackage

FILE: rtl/optimal_page_replacement.sv
// A run of N references starts replay once the last one transfers; a hit
// needs no scan, while a miss is resolved by the one-entry-per-cycle forward
// scan of the reference store's read port over the rest of the run.
// Loading takes one reference per cycle; loading stalls while a run replays.
// Reset (synchronous, active low) empties the frames and clears the load, fault and hit counts.
// ----------------------------------------------------------------------------
// optimal_page_replacement: Belady optimal page replacement
// Front loads the reference string into RAM, back replays it and reports.
// ----------------------------------------------------------------------------
module optimal_page_replacement #(
    parameter int unsigned NUM_FRAMES = 3,
    parameter int unsigned MAX_REFS   = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [opr_pkg::PageW-1:0] i_page_number,
    input  logic                      i_last_ref,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_was_hit,
    output logic [opr_pkg::SlotW-1:0] o_frame_slot,
    output logic [opr_pkg::PageW-1:0] o_ref_page,
    output logic                      o_evicted_valid,
    output logic [opr_pkg::PageW-1:0] o_evicted_page,
    output logic [opr_pkg::CntW-1:0]  o_fault_total,
    output logic [opr_pkg::CntW-1:0]  o_hit_total,
    output logic                      o_last_of_run
);
    import opr_pkg::*;

    localparam int unsigned AW = $clog2(MAX_REFS);

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [PageW-1:0] wdata, rdata;
    logic             cmd_valid, cmd_take;
    t_run_cmd         cmd;

    opr_front #(.MaxRefs(MAX_REFS)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_page_number, .i_last_ref,
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata),
        .o_cmd_valid(cmd_valid), .o_cmd(cmd), .i_cmd_take(cmd_take)
    );

    // reference store
    opr_ram #(.Width(PageW), .Depth(MAX_REFS)) u_store (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    // the run command stays posted until the last result is issued
    opr_back #(.NumFrames(NUM_FRAMES), .MaxRefs(MAX_REFS)) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .i_cmd(cmd),
        .o_cmd_take(cmd_take), .o_raddr(raddr), .i_rdata(rdata),
        .o_valid, .i_stall, .o_was_hit, .o_frame_slot, .o_ref_page,
        .o_evicted_valid, .o_evicted_page, .o_fault_total, .o_hit_total,
        .o_last_of_run
    );

`ifndef SYNTHESIS
    // hit and eviction are exclusive on every result
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_was_hit |-> !o_evicted_valid)
        else $error("hit reported with eviction");
    // loading never overlaps a pending run command
    a_no_load_during_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid |-> o_stall)
        else $error("load accepted while run pending");
    // store is never written while the replay reads it
    a_no_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_valid |-> !we)
        else $error("store written during run");
`endif
endmodule

FILE: rtl/opr_ram.sv
// ----------------------------------------------------------------------------
// opr_ram: generic single-write, single-read RAM
// Synchronous write, registered read.
// ----------------------------------------------------------------------------
module opr_ram #(
    parameter int unsigned Width = 16,
    parameter int unsigned Depth = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/opr_front.sv
// ----------------------------------------------------------------------------
// opr_front: reference loader
// Writes page numbers into the store, counts them and posts a run command
// when the string ends (last flag or store full).
// ----------------------------------------------------------------------------
module opr_front #(
    parameter int unsigned MaxRefs = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [opr_pkg::PageW-1:0]  i_page_number,
    input  logic                       i_last_ref,
    output logic                       o_we,
    output logic [$clog2(MaxRefs)-1:0] o_waddr,
    output logic [opr_pkg::PageW-1:0]  o_wdata,
    output logic                       o_cmd_valid,
    output opr_pkg::t_run_cmd          o_cmd,
    input  logic                       i_cmd_take
);
    import opr_pkg::*;

    localparam int unsigned AW = $clog2(MaxRefs);

    logic [CntW-1:0] r_count, n_count;
    logic            r_cmd_valid, n_cmd_valid;
    logic [CntW-1:0] r_cmd_len, n_cmd_len;
    logic            acc;
    logic [CntW-1:0] cnt_inc;

    // one-entry command queue; loading waits while a run is pending
    assign o_stall = r_cmd_valid;
    assign acc     = i_valid && !r_cmd_valid;
    assign cnt_inc = r_count + CntW'(1);

    always_comb begin
        n_count     = r_count;
        n_cmd_valid = r_cmd_valid;
        n_cmd_len   = r_cmd_len;
        if (i_cmd_take) begin
            n_cmd_valid = 1'b0;
        end
        if (acc) begin
            if (i_last_ref || cnt_inc == CntW'(MaxRefs)) begin
                n_cmd_valid = 1'b1;
                n_cmd_len   = cnt_inc;
                n_count     = '0;
            end else begin
                n_count = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_cmd_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_cmd_valid <= n_cmd_valid;
        end
        r_cmd_len <= n_cmd_len;
    end

    assign o_we        = acc;
    assign o_waddr     = r_count[AW-1:0];
    assign o_wdata     = i_page_number;
    assign o_cmd_valid = r_cmd_valid;
    assign o_cmd.len   = r_cmd_len;
endmodule

FILE: rtl/opr_back.sv
// ----------------------------------------------------------------------------
// opr_back: replay sequencer
// Replays the stored string through the frames; on a miss it scans the rest
// of the string once, tracking the next use of every frame in parallel.
// ----------------------------------------------------------------------------
module opr_back #(
    parameter int unsigned NumFrames = 3,
    parameter int unsigned MaxRefs   = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cmd_valid,
    input  opr_pkg::t_run_cmd          i_cmd,
    output logic                       o_cmd_take,
    output logic [$clog2(MaxRefs)-1:0] o_raddr,
    input  logic [opr_pkg::PageW-1:0]  i_rdata,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_was_hit,
    output logic [opr_pkg::SlotW-1:0]  o_frame_slot,
    output logic [opr_pkg::PageW-1:0]  o_ref_page,
    output logic                       o_evicted_valid,
    output logic [opr_pkg::PageW-1:0]  o_evicted_page,
    output logic [opr_pkg::CntW-1:0]   o_fault_total,
    output logic [opr_pkg::CntW-1:0]   o_hit_total,
    output logic                       o_last_of_run
);
    import opr_pkg::*;

    localparam int unsigned AW = $clog2(MaxRefs);
    localparam int unsigned FW = (NumFrames > 1) ? $clog2(NumFrames) : 1;

    t_rp_state r_state, n_state;

    logic [PageW-1:0] r_fpage [NumFrames];
    logic [NumFrames-1:0] r_fvalid, n_fvalid;
    logic [NumFrames-1:0] r_found, n_found;
    logic [CntW-1:0]  r_dist [NumFrames];
    logic [CntW-1:0]  r_len, n_len;
    logic [CntW-1:0]  r_pos, n_pos;
    logic [CntW-1:0]  r_scan, n_scan;
    logic [CntW-1:0]  r_faults, n_faults;
    logic [CntW-1:0]  r_hits, n_hits;
    logic [PageW-1:0] r_cur, n_cur;
    logic             r_shit, n_shit;
    logic [SlotW-1:0] r_sslot, n_sslot;
    logic             r_sev, n_sev;
    logic [PageW-1:0] r_sevp, n_sevp;
    logic             r_ov, n_ov;
    logic             r_ohit, n_ohit;
    logic [SlotW-1:0] r_oslot, n_oslot;
    logic [PageW-1:0] r_opage, n_opage;
    logic             r_oev, n_oev;
    logic [PageW-1:0] r_oevp, n_oevp;
    logic [CntW-1:0]  r_ofl, n_ofl;
    logic [CntW-1:0]  r_oht, n_oht;
    logic             r_olast, n_olast;

    logic             hit_any;
    logic [FW-1:0]    hit_idx;
    logic [FW-1:0]    vic;
    logic             vic_free;
    logic [CntW-1:0]  best;
    logic             upd_frame;
    logic [FW-1:0]    upd_idx;
    logic             scan_cyc;
    logic             dist_clr;

    // hit lookup against the fetched page
    always_comb begin
        hit_any = 1'b0;
        hit_idx = '0;
        for (int f = NumFrames - 1; f >= 0; f--) begin
            if (r_fvalid[f] && r_fpage[f] == i_rdata) begin
                hit_any = 1'b1;
                hit_idx = FW'(f);
            end
        end
    end

    // victim choice after the scan: first empty/unused frame, else farthest
    always_comb begin
        vic      = '0;
        vic_free = 1'b0;
        best     = '0;
        for (int f = NumFrames - 1; f >= 0; f--) begin
            if (!r_fvalid[f] || !r_found[f]) begin
                vic      = FW'(f);
                vic_free = 1'b1;
            end
        end
        if (!vic_free) begin
            for (int f = 0; f < NumFrames; f++) begin
                if (r_dist[f] > best) begin
                    best = r_dist[f];
                    vic  = FW'(f);
                end
            end
        end
    end

    assign o_raddr = (r_state == ST_SCAN) ? r_scan[AW-1:0] : r_pos[AW-1:0];

    always_comb begin
        n_state    = r_state;
        n_fvalid   = r_fvalid;
        n_found    = r_found;
        n_len      = r_len;
        n_pos      = r_pos;
        n_scan     = r_scan;
        n_faults   = r_faults;
        n_hits     = r_hits;
        n_cur      = r_cur;
        n_shit     = r_shit;
        n_sslot    = r_sslot;
        n_sev      = r_sev;
        n_sevp     = r_sevp;
        n_ov       = r_ov;
        n_ohit     = r_ohit;
        n_oslot    = r_oslot;
        n_opage    = r_opage;
        n_oev      = r_oev;
        n_oevp     = r_oevp;
        n_ofl      = r_ofl;
        n_oht      = r_oht;
        n_olast    = r_olast;
        o_cmd_take = 1'b0;
        upd_frame  = 1'b0;
        upd_idx    = '0;
        scan_cyc   = 1'b0;
        dist_clr   = 1'b0;

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                // command stays posted until the run is done, holding off loads
                if (i_cmd_valid) begin
                    n_len      = i_cmd.len;
                    n_pos      = '0;
                    n_fvalid   = '0;
                    n_faults   = '0;
                    n_hits     = '0;
                    n_state    = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_HITCHK;
            end
            ST_HITCHK: begin
                n_cur = i_rdata;
                if (hit_any) begin
                    n_shit  = 1'b1;
                    n_sslot = SlotW'(hit_idx);
                    n_sev   = 1'b0;
                    n_sevp  = '0;
                    n_hits  = r_hits + CntW'(1);
                    n_state = ST_EMIT;
                end else begin
                    n_found  = '0;
                    dist_clr = 1'b1;
                    n_scan   = r_pos + CntW'(1);
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // one store entry per cycle; read data belongs to the previous scan address
                scan_cyc = (r_scan > r_pos + CntW'(1));
                if (r_scan > r_len) begin
                    n_shit    = 1'b0;
                    n_sslot   = SlotW'(vic);
                    n_sev     = r_fvalid[vic];
                    n_sevp    = r_fvalid[vic] ? r_fpage[vic] : '0;
                    n_faults  = r_faults + CntW'(1);
                    upd_frame = 1'b1;
                    upd_idx   = vic;
                    n_fvalid[vic] = 1'b1;
                    n_state   = ST_EMIT;
                end else begin
                    n_scan = r_scan + CntW'(1);
                end
            end
            ST_EMIT: begin
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_ohit  = r_shit;
                    n_oslot = r_sslot;
                    n_oev   = r_sev;
                    n_oevp  = r_sevp;
                    n_opage = r_cur;
                    n_ofl   = r_faults;
                    n_oht   = r_hits;
                    n_olast = (r_pos + CntW'(1) == r_len);
                    n_pos   = r_pos + CntW'(1);
                    o_cmd_take = (r_pos + CntW'(1) == r_len);
                    n_state = (r_pos + CntW'(1) == r_len) ? ST_IDLE : ST_FETCH;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (scan_cyc) begin
            for (int f = 0; f < NumFrames; f++) begin
                if (!r_found[f] && r_fpage[f] == i_rdata) begin
                    n_found[f] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_fvalid <= '0;
            r_ov     <= 1'b0;
            r_faults <= '0;
            r_hits   <= '0;
        end else begin
            r_state  <= n_state;
            r_fvalid <= n_fvalid;
            r_ov     <= n_ov;
            r_faults <= n_faults;
            r_hits   <= n_hits;
        end
        r_found <= n_found;
        r_len   <= n_len;
        r_pos   <= n_pos;
        r_scan  <= n_scan;
        r_cur   <= n_cur;
        r_shit  <= n_shit;
        r_sslot <= n_sslot;
        r_sev   <= n_sev;
        r_sevp  <= n_sevp;
        r_ohit  <= n_ohit;
        r_oslot <= n_oslot;
        r_opage <= n_opage;
        r_oev   <= n_oev;
        r_oevp  <= n_oevp;
        r_ofl   <= n_ofl;
        r_oht   <= n_oht;
        r_olast <= n_olast;
        for (int f = 0; f < NumFrames; f++) begin
            if (upd_frame && upd_idx == FW'(f)) begin
                r_fpage[f] <= r_cur;
            end
            if (dist_clr) begin
                r_dist[f] <= '0;
            end else if (scan_cyc && !r_found[f] && r_fpage[f] == i_rdata) begin
                // position of this entry is r_scan - 1
                r_dist[f] <= r_scan - CntW'(1);
            end
        end
    end

    assign o_valid         = r_ov;
    assign o_was_hit       = r_ohit;
    assign o_frame_slot    = r_oslot;
    assign o_ref_page      = r_opage;
    assign o_evicted_valid = r_oev;
    assign o_evicted_page  = r_oevp;
    assign o_fault_total   = r_ofl;
    assign o_hit_total     = r_oht;
    assign o_last_of_run   = r_olast;
endmodule
